[rtl/lfp_pkg.sv]
// Shared types and constants for the lane frame parser.
package lfp_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'hAA;
  localparam logic [7:0]  LANE_KIND      = 8'h01;
  // Byte position reached just before the last byte of a frame.
  localparam logic [3:0]  LANE_LAST_POS  = 4'd10;
  localparam logic [3:0]  OTHER_LAST_POS = 4'd11;
  // Only the first nine payload bytes are kept; the checksum byte is used on arrival.
  localparam int unsigned STORE_DEPTH    = 9;
  localparam int unsigned STORE_AW       = $clog2(STORE_DEPTH);
  localparam logic [STORE_AW-1:0] VALID_IDX = STORE_AW'(8);
  localparam logic [15:0] TIMEOUT_RESET  = 16'd200;
  localparam logic [15:0] TICK_MAX       = 16'hFFFF;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] offset_bits;
    logic [31:0] angle_bits;
    logic        target_valid;
    logic        frame_accepted;
    logic        checksum_error;
  } result_t;

endpackage

[rtl/lfp_in_stage.sv]
// Input register stage: holds one accepted item until the parser takes it.
module lfp_in_stage
  import lfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
    if (take) begin
      item_d.func      = func_e'(func_i);
      item_d.data_byte = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/lfp_parser.sv]
// Frame parser state, payload store, latched lane values and tick counter.
module lfp_parser
  import lfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  item_t       item_i,
  input  logic [15:0] timeout_ticks_i,
  output result_t     result_o
);

  logic        in_sync_q, in_sync_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  xor_q, xor_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] angle_q, angle_d;
  logic        valid_q, valid_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  store_q [STORE_DEPTH];
  logic [3:0]  idx;
  logic        store_we;
  logic        accepted, bad;
  logic [7:0]  b;

  assign b        = item_i.data_byte;
  assign idx      = pos_q - 4'd1;
  assign store_we = step_i && (item_i.func == FUNC_BYTE) && in_sync_q && (pos_q != 4'd0)
                    && (idx < 4'(STORE_DEPTH));

  always_comb begin
    in_sync_d = in_sync_q;
    pos_d     = pos_q;
    kind_d    = kind_q;
    xor_d     = xor_q;
    offset_d  = offset_q;
    angle_d   = angle_q;
    valid_d   = valid_q;
    elapsed_d = elapsed_q;
    accepted  = 1'b0;
    bad       = 1'b0;
    if (item_i.func == FUNC_TICK) begin
      // Saturating count, then drop the valid flag once past the timeout.
      if (elapsed_q != TICK_MAX) begin
        elapsed_d = elapsed_q + 16'd1;
      end
      if (elapsed_d > timeout_ticks_i) begin
        valid_d = 1'b0;
      end
    end else if (!in_sync_q) begin
      if (b == SYNC_BYTE) begin
        in_sync_d = 1'b1;
        pos_d     = 4'd0;
        kind_d    = 8'd0;
        xor_d     = 8'd0;
      end
    end else if (pos_q == 4'd0) begin
      kind_d = b;
      pos_d  = 4'd1;
    end else begin
      pos_d = pos_q + 4'd1;
      if (idx < 4'(STORE_DEPTH)) begin
        xor_d = xor_q ^ b;
      end
      if (kind_q == LANE_KIND && pos_q == LANE_LAST_POS) begin
        if ((SYNC_BYTE ^ LANE_KIND ^ xor_q) == b) begin
          offset_d  = {store_q[3], store_q[2], store_q[1], store_q[0]};
          angle_d   = {store_q[7], store_q[6], store_q[5], store_q[4]};
          valid_d   = store_q[VALID_IDX] != 8'd0;
          elapsed_d = 16'd0;
          accepted  = 1'b1;
        end else begin
          bad = 1'b1;
        end
        in_sync_d = 1'b0;
        pos_d     = 4'd0;
      end else if (pos_q == OTHER_LAST_POS) begin
        in_sync_d = 1'b0;
        pos_d     = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sync_q <= 1'b0;
      pos_q     <= 4'd0;
      kind_q    <= 8'd0;
      xor_q     <= 8'd0;
      offset_q  <= 32'd0;
      angle_q   <= 32'd0;
      valid_q   <= 1'b0;
      elapsed_q <= 16'd0;
    end else if (step_i) begin
      in_sync_q <= in_sync_d;
      pos_q     <= pos_d;
      kind_q    <= kind_d;
      xor_q     <= xor_d;
      offset_q  <= offset_d;
      angle_q   <= angle_d;
      valid_q   <= valid_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[idx[STORE_AW-1:0]] <= b;
    end
  end

  always_comb begin
    result_o.offset_bits    = offset_d;
    result_o.angle_bits     = angle_d;
    result_o.target_valid   = valid_d;
    result_o.frame_accepted = accepted;
    result_o.checksum_error = bad;
  end

endmodule

[rtl/lfp_out_stage.sv]
// Result register: holds one result item until the consumer takes it.
module lfp_out_stage
  import lfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t result_i,
  output logic    advance_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q, result_d;

  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d  = valid_q;
    result_d = result_q;
    if (advance_o) begin
      valid_d  = valid_i;
      result_d = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[rtl/lane_frame_parser_with_timeout_core.sv]
// Top level of the lane frame parser with tick timeout.
// Throughput: one item per cycle; each item passes the input register, the parser logic
// and the result register, and both registers advance together when the output drains.
// Reset (rst_ni low, asynchronous): hunt for sync, clear latched lane values, valid flag
// and tick count, set timeout to 200 ticks; the payload store is not cleared.
module lane_frame_parser_with_timeout_core
  import lfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] offset_bits_o,
  output logic [31:0] angle_bits_o,
  output logic        target_valid_o,
  output logic        frame_accepted_o,
  output logic        checksum_error_o,
  // Timeout register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic        advance;
  logic        stage_valid;
  item_t       stage_item;
  result_t     next_result;
  result_t     out_result;
  logic [15:0] timeout_q;

  // Timeout register always writable; user must write only while idle (not enforced).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Hold the incoming item until the parser takes it.
  lfp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .advance_i   (advance),
    .valid_o     (stage_valid),
    .item_o      (stage_item)
  );

  // Advance the parser state only when the held item moves into the result register.
  lfp_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (stage_valid && advance),
    .item_i          (stage_item),
    .timeout_ticks_i (timeout_q),
    .result_o        (next_result)
  );

  // Result register, parting the parser from the consumer.
  lfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .result_i    (next_result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign offset_bits_o    = out_result.offset_bits;
  assign angle_bits_o     = out_result.angle_bits;
  assign target_valid_o   = out_result.target_valid;
  assign frame_accepted_o = out_result.frame_accepted;
  assign checksum_error_o = out_result.checksum_error;

endmodule

[rtl/lfp_checker.sv]
// Port-level checks for the lane frame parser, bound to the top level.
module lfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] offset_bits_o,
  input logic [31:0] angle_bits_o,
  input logic        target_valid_o,
  input logic        frame_accepted_o,
  input logic        checksum_error_o
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(offset_bits_o)
      && $stable(angle_bits_o) && $stable(target_valid_o)
      && $stable(frame_accepted_o) && $stable(checksum_error_o))
    else $error("stalled result item changed");

  // A result item never shows both an accepted frame and a checksum error.
  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_accepted_o && checksum_error_o))
    else $error("accept and checksum error together");

  // With the result register empty, the input side must take items.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // An item taken while the result register is empty is followed by a valid result item.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##[1:2] out_valid_o)
    else $error("accepted item produced no result");

endmodule

bind lane_frame_parser_with_timeout_core lfp_checker u_lfp_checker (.*);

[verif/testbench.sv]
// Self-checking testbench for the lane frame parser with tick timeout.
`timescale 1ns / 1ps

module testbench;
  import lfp_pkg::*;

  // Clock, reset and the block's inputs, all known from time zero
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        func_in     = 1'b0;
  logic [7:0]  byte_in     = 8'h00;
  logic        out_ready   = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [15:0] cfg_data    = 16'd0;

  logic        in_ready;
  logic        out_valid;
  logic [31:0] offset_out;
  logic [31:0] angle_out;
  logic        tvalid_out;
  logic        accepted_out;
  logic        cksum_err_out;
  logic        cfg_ready;

  // Idling is switched off for the closing stretch of the run
  bit          steady      = 1'b0;
  int          stall_left  = 0;
  int          error_count = 0;
  int          items_sent  = 0;

  // Expected result items, oldest first
  result_t     expected_results[$];

  // Parser state as predicted by the testbench
  logic        par_in_sync;
  logic [3:0]  par_pos;
  logic [7:0]  par_kind;
  logic [7:0]  par_bytes [10];
  logic [31:0] par_offset;
  logic [31:0] par_angle;
  logic        par_valid;
  logic [15:0] par_elapsed;
  logic [15:0] par_timeout;

  lane_frame_parser_with_timeout_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (func_in),
    .data_byte_i      (byte_in),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .offset_bits_o    (offset_out),
    .angle_bits_o     (angle_out),
    .target_valid_o   (tvalid_out),
    .frame_accepted_o (accepted_out),
    .checksum_error_o (cksum_err_out),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, driven on the falling edge
  always @(negedge clk) begin
    if (steady) begin
      out_ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ready  = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready = 1'b1;
      if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
    end
  end

  // One line per mismatch; cap the printing but keep counting
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < 40)
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    error_count = error_count + 1;
  endtask

  task automatic reset_parser_model();
    par_in_sync = 1'b0;
    par_pos     = 4'd0;
    par_kind    = 8'h00;
    for (int i = 0; i < 10; i++) par_bytes[i] = 8'h00;
    par_offset  = 32'd0;
    par_angle   = 32'd0;
    par_valid   = 1'b0;
    par_elapsed = 16'd0;
    par_timeout = TIMEOUT_RESET;
  endtask

  // Advance the predicted parser by one item and queue the result it shows
  task automatic predict_parser_step(func_e f, logic [7:0] b);
    result_t    res;
    logic [7:0] calc;
    logic [3:0] slot;
    res = '0;
    if (f == FUNC_TICK) begin
      if (par_elapsed != TICK_MAX) par_elapsed = par_elapsed + 16'd1;
      if (par_elapsed > par_timeout) par_valid = 1'b0;
    end else if (!par_in_sync) begin
      if (b == SYNC_BYTE) begin
        par_in_sync = 1'b1;
        par_pos     = 4'd0;
        par_kind    = 8'h00;
      end
    end else if (par_pos == 4'd0) begin
      par_kind = b;
      par_pos  = 4'd1;
    end else begin
      slot = par_pos - 4'd1;
      if (slot < 4'd10) par_bytes[slot] = b;
      par_pos = par_pos + 4'd1;
      if (par_kind == LANE_KIND && par_pos >= LANE_LAST_POS + 4'd1) begin
        calc = SYNC_BYTE ^ LANE_KIND;
        for (int i = 0; i < 9; i++) calc = calc ^ par_bytes[i];
        if (calc == par_bytes[9]) begin
          par_offset  = {par_bytes[3], par_bytes[2], par_bytes[1], par_bytes[0]};
          par_angle   = {par_bytes[7], par_bytes[6], par_bytes[5], par_bytes[4]};
          par_valid   = (par_bytes[8] != 8'h00);
          par_elapsed = 16'd0;
          res.frame_accepted = 1'b1;
        end else begin
          res.checksum_error = 1'b1;
        end
        par_in_sync = 1'b0;
        par_pos     = 4'd0;
      end else if (par_pos >= OTHER_LAST_POS + 4'd1) begin
        par_in_sync = 1'b0;
        par_pos     = 4'd0;
      end
    end
    res.offset_bits  = par_offset;
    res.angle_bits   = par_angle;
    res.target_valid = par_valid;
    expected_results.push_back(res);
  endtask

  // Compare every accepted result item against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item", offset_out, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (offset_out !== want.offset_bits)
          report_mismatch("offset_bits", offset_out, want.offset_bits);
        if (angle_out !== want.angle_bits)
          report_mismatch("angle_bits", angle_out, want.angle_bits);
        if (tvalid_out !== want.target_valid)
          report_mismatch("target_valid", {31'd0, tvalid_out}, {31'd0, want.target_valid});
        if (accepted_out !== want.frame_accepted)
          report_mismatch("frame_accepted", {31'd0, accepted_out},
                          {31'd0, want.frame_accepted});
        if (cksum_err_out !== want.checksum_error)
          report_mismatch("checksum_error", {31'd0, cksum_err_out},
                          {31'd0, want.checksum_error});
      end
    end
  end

  // Send one item; valid stays high into the next call unless a gap is taken
  task automatic send_item(func_e f, logic [7:0] b);
    @(negedge clk);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    func_in  = f;
    byte_in  = b;
    do @(posedge clk); while (!in_ready);
    predict_parser_step(f, b);
    items_sent = items_sent + 1;
  endtask

  // Hold the sender off until every expected result has come, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    par_timeout = value;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = 16'($urandom_range(0, 65535));
  endtask

  // Lane frame: sync, kind, nine body bytes, checksum; ticks may fall between bytes
  task automatic send_lane_frame(logic [71:0] body, bit corrupt, int tick_odds);
    logic [7:0] calc;
    calc = SYNC_BYTE ^ LANE_KIND;
    send_item(FUNC_BYTE, SYNC_BYTE);
    send_item(FUNC_BYTE, LANE_KIND);
    for (int i = 0; i < 9; i++) begin
      if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1)
        send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
      send_item(FUNC_BYTE, body[8*i +: 8]);
      calc = calc ^ body[8*i +: 8];
    end
    if (corrupt) calc = calc ^ 8'($urandom_range(1, 255));
    send_item(FUNC_BYTE, calc);
  endtask

  // Foreign frame: sync, kind, eleven bytes that are dropped
  task automatic send_other_frame(logic [7:0] kind);
    send_item(FUNC_BYTE, SYNC_BYTE);
    send_item(FUNC_BYTE, kind);
    for (int i = 0; i < 11; i++) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [71:0] random_body();
    logic [71:0] body;
    body = {8'($urandom), $urandom, $urandom};
    // Leave the valid byte at zero now and then
    if ($urandom_range(0, 3) == 0) body[71:64] = 8'h00;
    return body;
  endfunction

  // Reset values on a tick and a stray byte while hunting
  task automatic test_reset_state();
    send_item(FUNC_TICK, 8'hFF);
    send_item(FUNC_BYTE, 8'h00);
  endtask

  // Extreme payload with a sync byte inside it, then a frame of another kind
  task automatic test_directed_frames();
    send_lane_frame({8'hFF, 8'h00, 8'h00, 8'h00, SYNC_BYTE,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 0);
    send_other_frame(8'hFF);
  endtask

  // A timeout of one, then a quiet spell at the largest one
  task automatic test_timeout_edges();
    write_timeout(16'd1);
    send_lane_frame({8'h01, $urandom, $urandom}, 1'b0, 0);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_TICK, 8'h00);
    write_timeout(16'hFFFF);
    send_lane_frame({8'h80, $urandom, $urandom}, 1'b0, 0);
    for (int i = 0; i < 20; i++) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
    // The count kept running, so a lower timeout drops the flag on the next tick
    write_timeout(16'd8);
    send_item(FUNC_TICK, 8'h00);
  endtask

  // Mostly well-formed frames with random content, some noise and broken frames
  task automatic test_random_traffic();
    int          phase_end;
    int          pick;
    logic [15:0] tmo;
    bit          drained;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: tmo = TIMEOUT_RESET;
        1: tmo = 16'($urandom_range(1, 8));
        2: tmo = 16'($urandom_range(9, 40));
        3: tmo = 16'hFFFF;
        4: tmo = 16'($urandom_range(1, 65535));
        default: tmo = 16'($urandom_range(2, 16));
      endcase
      write_timeout(tmo);
      // Drop all idling in the closing phase
      if (phase == 5) steady = 1'b1;
      drained   = 1'b0;
      phase_end = items_sent + 250;
      while (items_sent < phase_end) begin
        if (!drained && items_sent > phase_end - 125) begin
          wait_drained();
          drained = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
          send_lane_frame(random_body(), $urandom_range(0, 4) == 0, 8);
        else if (pick < 72)
          send_other_frame(8'($urandom_range(0, 255)));
        else if (pick < 86)
          repeat ($urandom_range(1, 20)) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
        else if (pick < 93)
          send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
        else begin
          // Broken frame: sync and a lane kind, cut short
          send_item(FUNC_BYTE, SYNC_BYTE);
          send_item(FUNC_BYTE, LANE_KIND);
          repeat ($urandom_range(1, 8)) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    reset_parser_model();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed_frames();
    test_timeout_edges();
    test_random_traffic();

    wait_drained();
    repeat (5) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("result items still expected", 32'(expected_results.size()), 32'd0);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
